// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the ordered key/value table checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk outside reset
`define OKVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, but also checked while reset is held
`define OKVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/okvt_pkg.sv -----
// ----------------------------------------------------------------------------
// okvt_pkg
// shared types and constants for the ordered key/value table
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int POS_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int INDEX_W    = 6;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // broadcast to every cell for the compare step
    typedef struct packed {
        logic                 en;
        logic                 by_index;
        logic [KEY_BITS-1:0]  key;
        logic [INDEX_W-1:0]   index;
        logic [CNT_W-1:0]     count;
    } okvt_match_t;

    // broadcast to every cell for the update step
    typedef struct packed {
        logic                  wr_en;
        logic                  wr_key_en;
        logic [POS_W-1:0]      wr_pos;
        logic [KEY_BITS-1:0]   wr_key;
        logic [VALUE_BITS-1:0] wr_value;
        logic                  shift_en;
        logic [POS_W-1:0]      shift_pos;
    } okvt_upd_t;

endpackage

// ----- sv/okvt_cell.sv -----
// ----------------------------------------------------------------------------
// okvt_cell
// one table slot: holds a key and a value, compares, and shifts down on erase
// ----------------------------------------------------------------------------
module okvt_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [okvt_pkg::POS_W-1:0]     pos,
    input  okvt_pkg::okvt_match_t          match,
    input  okvt_pkg::okvt_upd_t            upd,
    input  logic [okvt_pkg::KEY_BITS-1:0]  nbr_key,
    input  logic [okvt_pkg::VALUE_BITS-1:0] nbr_value,
    output logic                           sel,
    output logic [okvt_pkg::KEY_BITS-1:0]  key,
    output logic [okvt_pkg::VALUE_BITS-1:0] value
);

    logic                            sel_reg;
    logic                            sel_next;
    logic [okvt_pkg::KEY_BITS-1:0]   key_reg;
    logic [okvt_pkg::VALUE_BITS-1:0] value_reg;
    logic                            in_use;

    assign in_use = {1'b0, pos} < okvt_pkg::CNT_W'(match.count);

    always_comb
    begin
        if (match.by_index)
            sel_next = in_use && (okvt_pkg::INDEX_W'(pos) == match.index);
        else
            sel_next = in_use && (key_reg == match.key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (match.en)
            sel_reg <= sel_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (upd.shift_en && (pos >= upd.shift_pos))
        begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
        else if (upd.wr_en && (pos == upd.wr_pos))
        begin
            value_reg <= upd.wr_value;
            if (upd.wr_key_en)
                key_reg <= upd.wr_key;
        end
    end

    assign sel   = sel_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

// ----- sv/ordered_key_value_table.sv -----
// ----------------------------------------------------------------------------
// ordered_key_value_table
// key/value table with unique keys kept in insertion order
// ----------------------------------------------------------------------------
// An item passes through three steps after it is accepted: one in which all
// 64 cells compare their key (or their slot number for a read at index) in
// parallel, one to fold the single matching cell into key, value and
// position, and one to update the cells and register the result. An erase
// shifts every later cell down one slot in that last step. A new item is
// taken only once the last one has left the update step, so the block works
// on one item at a time. It is taken even if the previous result has not yet
// been taken; the update step waits while an earlier result is still
// pending. After reset the table is empty.
module ordered_key_value_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key[31:0], value[63:32], index[69:64], zero pad
    input  logic [4:0]  s_tuser,   // opcode[2:0], may_insert[3], may_update[4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // found_value[31:0], found_key[63:32],
                                   // position[69:64], entry_count[76:70], zero pad
    output logic [1:0]  m_tuser    // ok[0], full_res[1]
);

    localparam int D  = okvt_pkg::DEPTH;
    localparam int KB = okvt_pkg::KEY_BITS;
    localparam int VB = okvt_pkg::VALUE_BITS;
    localparam int PW = okvt_pkg::POS_W;
    localparam int CW = okvt_pkg::CNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_REDUCE, ST_APPLY} state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 count_reg;
    logic [okvt_pkg::OP_W-1:0]     op_reg;
    logic [KB-1:0]                 key_reg;
    logic [VB-1:0]                 value_reg;
    logic [okvt_pkg::INDEX_W-1:0]  index_reg;
    logic                          may_ins_reg;
    logic                          may_upd_reg;

    logic                          hit_reg;
    logic [PW-1:0]                 hpos_reg;
    logic [KB-1:0]                 hkey_reg;
    logic [VB-1:0]                 hvalue_reg;

    logic                          m_tvalid_reg;
    logic                          ok_reg;
    logic                          full_reg;
    logic [VB-1:0]                 fval_reg;
    logic [KB-1:0]                 fkey_reg;
    logic [PW-1:0]                 pos_reg;

    logic                          hit_next;
    logic [PW-1:0]                 hpos_next;
    logic [KB-1:0]                 hkey_next;
    logic [VB-1:0]                 hvalue_next;

    logic                          ok_next;
    logic                          full_next;
    logic [VB-1:0]                 fval_next;
    logic [KB-1:0]                 fkey_next;
    logic [PW-1:0]                 pos_next;
    logic [CW-1:0]                 count_next;

    logic                          accept;
    logic                          advance;

    okvt_pkg::okvt_match_t         match;
    okvt_pkg::okvt_upd_t           upd;
    okvt_pkg::okvt_upd_t           upd_calc;

    logic                          cell_sel   [D];
    logic [KB-1:0]                 cell_key   [D];
    logic [VB-1:0]                 cell_value [D];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);

    assign match.en       = (state_reg == ST_MATCH);
    assign match.by_index = (op_reg == okvt_pkg::OP_READ);
    assign match.key      = key_reg;
    assign match.index    = index_reg;
    assign match.count    = count_reg;

    // row of cells, each one but the top reads the slot above it on an erase
    for (genvar g = 0; g < D; g++)
    begin : g_cell
        logic [KB-1:0] nk;
        logic [VB-1:0] nv;
        if (g == D - 1)
        begin : g_top
            assign nk = '0;
            assign nv = '0;
        end
        else
        begin : g_mid
            assign nk = cell_key[g+1];
            assign nv = cell_value[g+1];
        end
        okvt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .pos       (PW'(g)),
            .match     (match),
            .upd       (upd),
            .nbr_key   (nk),
            .nbr_value (nv),
            .sel       (cell_sel[g]),
            .key       (cell_key[g]),
            .value     (cell_value[g])
        );
    end

    // at most one cell matches: keys are unique, slot numbers too
    always_comb
    begin
        hit_next    = 1'b0;
        hpos_next   = '0;
        hkey_next   = '0;
        hvalue_next = '0;
        for (int i = 0; i < D; i++)
        begin
            hit_next    = hit_next | cell_sel[i];
            hpos_next   = hpos_next | (PW'(i) & {PW{cell_sel[i]}});
            hkey_next   = hkey_next | (cell_key[i] & {KB{cell_sel[i]}});
            hvalue_next = hvalue_next | (cell_value[i] & {VB{cell_sel[i]}});
        end
    end

    always_comb
    begin
        ok_next    = 1'b0;
        full_next  = 1'b0;
        fval_next  = '0;
        fkey_next  = '0;
        pos_next   = '0;
        count_next = count_reg;
        upd_calc   = '0;
        upd_calc.wr_key   = key_reg;
        upd_calc.wr_value = value_reg;
        case (op_reg)
            okvt_pkg::OP_WRITE:
            begin
                if (hit_reg)
                begin
                    if (may_upd_reg)
                    begin
                        upd_calc.wr_en  = 1'b1;
                        upd_calc.wr_pos = hpos_reg;
                        ok_next         = 1'b1;
                        pos_next        = hpos_reg;
                    end
                end
                else if (may_ins_reg)
                begin
                    if (count_reg == CW'(D))
                        full_next = 1'b1;
                    else
                    begin
                        upd_calc.wr_en     = 1'b1;
                        upd_calc.wr_key_en = 1'b1;
                        upd_calc.wr_pos    = count_reg[PW-1:0];
                        pos_next           = count_reg[PW-1:0];
                        count_next         = count_reg + CW'(1);
                        ok_next            = 1'b1;
                    end
                end
            end
            okvt_pkg::OP_ERASE:
            begin
                if (hit_reg)
                begin
                    upd_calc.shift_en  = 1'b1;
                    upd_calc.shift_pos = hpos_reg;
                    count_next         = count_reg - CW'(1);
                    ok_next            = 1'b1;
                end
            end
            okvt_pkg::OP_LOOKUP:
            begin
                ok_next   = hit_reg;
                fval_next = hvalue_reg;
            end
            okvt_pkg::OP_FIND:
            begin
                ok_next  = hit_reg;
                pos_next = hpos_reg;
            end
            okvt_pkg::OP_READ:
            begin
                ok_next   = hit_reg;
                fkey_next = hkey_reg;
                fval_next = hvalue_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        upd = upd_calc;
        if (!advance)
        begin
            upd.wr_en    = 1'b0;
            upd.shift_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_MATCH;
                end
                ST_MATCH:
                begin
                    state_reg <= ST_REDUCE;
                end
                ST_REDUCE:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (advance)
                    begin
                        state_reg <= ST_IDLE;
                        count_reg <= count_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tuser[2:0];
            may_ins_reg <= s_tuser[3];
            may_upd_reg <= s_tuser[4];
            key_reg     <= s_tdata[31:0];
            value_reg   <= s_tdata[63:32];
            index_reg   <= s_tdata[69:64];
        end
        if (state_reg == ST_REDUCE)
        begin
            hit_reg    <= hit_next;
            hpos_reg   <= hpos_next;
            hkey_reg   <= hkey_next;
            hvalue_reg <= hvalue_next;
        end
        if (advance)
        begin
            ok_reg   <= ok_next;
            full_reg <= full_next;
            fval_reg <= fval_next;
            fkey_reg <= fkey_next;
            pos_reg  <= pos_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, count_reg, pos_reg, fkey_reg, fval_reg};
    assign m_tuser  = {full_reg, ok_reg};

endmodule

// ----- sv/okvt_checker.sv -----
// ----------------------------------------------------------------------------
// okvt_checker
// port-level checks for the ordered key/value table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module okvt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one item in flight: input closes right after an item is taken
    `OKVT_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")

    // entry count never passes the table depth
    `OKVT_ASSERT(a_count_bound, m_tvalid |-> (m_tdata[76:70] <= 7'(okvt_pkg::DEPTH)), "entry count above depth")

    // a refused insert never reports success
    `OKVT_ASSERT(a_full_not_ok, (m_tvalid && m_tuser[1]) |-> !m_tuser[0], "full and ok together")

    // a stalled result holds
    `OKVT_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streaming bench for the ordered key/value table. A directed list covers
// empty-table behavior, the write flags, erase with gap closing, the out of
// range index, the unused opcodes and the key extremes. It is followed by
// random operations over small key pools, a fill past capacity, a drain by
// erase and a final mixed run. Every reply is checked against a shadow table
// kept in the bench, or against values typed into the directed list.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [okvt_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam int IDLE_PCT       = 38;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 80;

    typedef struct packed {
        logic [okvt_pkg::OP_W-1:0]       opcode;
        logic [okvt_pkg::KEY_BITS-1:0]   key;
        logic [okvt_pkg::VALUE_BITS-1:0] value;
        logic [okvt_pkg::INDEX_W-1:0]    index;
        logic                            may_insert;
        logic                            may_update;
    } table_op_t;

    typedef struct packed {
        logic                            ok;
        logic [okvt_pkg::VALUE_BITS-1:0] found_value;
        logic [okvt_pkg::KEY_BITS-1:0]   found_key;
        logic [okvt_pkg::POS_W-1:0]      position;
        logic [okvt_pkg::CNT_W-1:0]      entry_count;
        logic                            full_res;
    } table_reply_t;

    typedef struct {
        table_op_t    op;
        bit           typed;
        table_reply_t reply;
    } script_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // key[31:0], value[63:32], index[69:64], zero pad
    logic [4:0]  s_tuser  = '0;   // opcode[2:0], may_insert[3], may_update[4]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // found_value[31:0], found_key[63:32],
                                  // position[69:64], entry_count[76:70], zero pad
    logic [1:0]  m_tuser;         // ok[0], full_res[1]

    // shadow copy of the table contents
    logic [okvt_pkg::KEY_BITS-1:0]   shadow_keys [okvt_pkg::DEPTH];
    logic [okvt_pkg::VALUE_BITS-1:0] shadow_values [okvt_pkg::DEPTH];
    int                              shadow_count = 0;

    table_reply_t                    replies_due[$];
    table_reply_t                    due;
    logic [okvt_pkg::KEY_BITS-1:0]   key_pool [POOL_SIZE];
    script_row_t                     script[$];
    int                              error_count = 0;
    int                              idle_cycles = 0;
    bit                              no_stall = 1'b0;

    ordered_key_value_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic table_op_t op_of(logic [okvt_pkg::OP_W-1:0] opcode,
                                        logic [okvt_pkg::KEY_BITS-1:0] key,
                                        logic [okvt_pkg::VALUE_BITS-1:0] value,
                                        logic [okvt_pkg::INDEX_W-1:0] index,
                                        logic ins, logic upd);
        table_op_t op;
        op = '{opcode, key, value, index, ins, upd};
        return op;
    endfunction

    function automatic table_reply_t reply_of(logic ok,
                                              logic [okvt_pkg::VALUE_BITS-1:0] fval,
                                              logic [okvt_pkg::KEY_BITS-1:0] fkey,
                                              logic [okvt_pkg::POS_W-1:0] pos,
                                              logic [okvt_pkg::CNT_W-1:0] cnt,
                                              logic full);
        table_reply_t r;
        r = '{ok, fval, fkey, pos, cnt, full};
        return r;
    endfunction

    // applies one operation to the shadow table and returns its reply
    function automatic table_reply_t apply_table_op(table_op_t op);
        table_reply_t r;
        int at;
        r = '0;
        at = -1;
        for (int i = 0; i < shadow_count; i++)
            if (at < 0 && shadow_keys[i] == op.key)
                at = i;
        case (op.opcode)
            okvt_pkg::OP_WRITE:
                if (at >= 0)
                begin
                    if (op.may_update)
                    begin
                        shadow_values[at] = op.value;
                        r.ok = 1'b1;
                        r.position = okvt_pkg::POS_W'(at);
                    end
                end
                else if (op.may_insert)
                begin
                    if (shadow_count >= okvt_pkg::DEPTH)
                        r.full_res = 1'b1;
                    else
                    begin
                        shadow_keys[shadow_count] = op.key;
                        shadow_values[shadow_count] = op.value;
                        r.position = okvt_pkg::POS_W'(shadow_count);
                        shadow_count++;
                        r.ok = 1'b1;
                    end
                end
            okvt_pkg::OP_ERASE:
                if (at >= 0)
                begin
                    // later entries slide down one slot
                    for (int i = at; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            okvt_pkg::OP_LOOKUP:
                if (at >= 0)
                begin
                    r.ok = 1'b1;
                    r.found_value = shadow_values[at];
                end
            okvt_pkg::OP_FIND:
                if (at >= 0)
                begin
                    r.ok = 1'b1;
                    r.position = okvt_pkg::POS_W'(at);
                end
            okvt_pkg::OP_READ:
                if (int'(op.index) < shadow_count)
                begin
                    r.ok = 1'b1;
                    r.found_key = shadow_keys[op.index];
                    r.found_value = shadow_values[op.index];
                end
            default:
                ;
        endcase
        r.entry_count = okvt_pkg::CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic table_op_t random_op(int pool_used, int write_pct);
        table_op_t op;
        int pick;
        op.key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_used - 1)];
        op.value = $urandom;
        op.may_insert = ($urandom_range(3) != 0);
        op.may_update = ($urandom_range(3) != 0);
        op.index = okvt_pkg::INDEX_W'($urandom_range(okvt_pkg::DEPTH - 1));
        pick = $urandom_range(99);
        if (pick < write_pct)
            op.opcode = okvt_pkg::OP_WRITE;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                op.opcode = okvt_pkg::OP_ERASE;
            else if (pick < 42)
                op.opcode = okvt_pkg::OP_LOOKUP;
            else if (pick < 64)
                op.opcode = okvt_pkg::OP_FIND;
            else if (pick < 94)
                op.opcode = okvt_pkg::OP_READ;
            else
                op.opcode = OP_UNUSED_LO + 3'($urandom_range(2));
        end
        // mostly aim reads at stored entries
        if (op.opcode == okvt_pkg::OP_READ && shadow_count > 0 && $urandom_range(4) != 0)
            op.index = okvt_pkg::INDEX_W'($urandom_range(shadow_count - 1));
        return op;
    endfunction

    task automatic send_op(input table_op_t op, input bit typed, input table_reply_t typed_reply);
        table_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, op.index, op.value, op.key};
        s_tuser  <= {op.may_update, op.may_insert, op.opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_table_op(op);
        replies_due.push_back(typed ? typed_reply : predicted);
        if (!no_stall && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: reply mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // reply side: random back-pressure and field checks
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("unexpected reply", m_tdata[31:0], '0);
                else
                begin
                    due = replies_due.pop_front();
                    if (m_tuser[0] !== due.ok)
                        report_mismatch("ok", m_tuser[0], due.ok);
                    if (m_tdata[31:0] !== due.found_value)
                        report_mismatch("found_value", m_tdata[31:0], due.found_value);
                    if (m_tdata[63:32] !== due.found_key)
                        report_mismatch("found_key", m_tdata[63:32], due.found_key);
                    if (m_tdata[69:64] !== due.position)
                        report_mismatch("position", m_tdata[69:64], due.position);
                    if (m_tdata[76:70] !== due.entry_count)
                        report_mismatch("entry_count", m_tdata[76:70], due.entry_count);
                    if (m_tuser[1] !== due.full_res)
                        report_mismatch("full_res", m_tuser[1], due.full_res);
                end
            end
            m_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        table_op_t op;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        script.push_back('{op_of(okvt_pkg::OP_READ, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_READ, 32'h0, 32'h0, 6'd63, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0, 1'b0),
                           1'b1, reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_FIND, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        // absent key without insert permission
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b1),
                           1'b1, reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd0, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0),
                           1'b1, reply_of(1'b1, 32'h0, 32'h0, 6'd0, 7'd1, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'h0, 6'd63, 1'b1, 1'b1),
                           1'b1, reply_of(1'b1, 32'h0, 32'h0, 6'd1, 7'd2, 1'b0)});
        // present key without update permission
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h0, 32'h1234_5678, 6'd0, 1'b1, 1'b0),
                           1'b1, reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h0, 32'hA5A5_A5A5, 6'd0, 1'b0, 1'b1),
                           1'b1, reply_of(1'b1, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b1, 32'hA5A5_A5A5, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_READ, 32'h0, 32'h0, 6'd1, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b1, 32'h0, 32'hFFFF_FFFF, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_READ, 32'h0, 32'h0, 6'd2, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_FIND, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0, 1'b0),
                           1'b1, reply_of(1'b1, 32'h0, 32'h0, 6'd1, 7'd2, 1'b0)});
        for (int u = 0; u < 3; u++)
            script.push_back('{op_of(OP_UNUSED_LO + 3'(u), 32'h0, 32'hFFFF_FFFF, 6'd63,
                                     1'b1, 1'b1),
                               1'b1, reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h5A5A_5A5A, 32'h3C3C_3C3C, 6'd0,
                                 1'b1, 1'b1),
                           1'b1, reply_of(1'b1, 32'h0, 32'h0, 6'd2, 7'd3, 1'b0)});
        // erase of the first entry moves the rest down
        script.push_back('{op_of(okvt_pkg::OP_ERASE, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b1, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_FIND, 32'h5A5A_5A5A, 32'h0, 6'd0, 1'b0, 1'b0),
                           1'b0, '0});
        script.push_back('{op_of(okvt_pkg::OP_READ, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        script.push_back('{op_of(okvt_pkg::OP_ERASE, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});
        script.push_back('{op_of(okvt_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 32'h0, 6'd0, 1'b0, 1'b0),
                           1'b0, '0});
        script.push_back('{op_of(okvt_pkg::OP_WRITE, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0), 1'b1,
                           reply_of(1'b0, 32'h0, 32'h0, 6'd0, 7'd2, 1'b0)});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_op(script[i].op, script[i].typed, script[i].reply);

        // mixed traffic over a small key set so most keys hit
        repeat (250)
            send_op(random_op(16, 35), 1'b0, '0);

        // hold off until the table has answered everything
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);

        // fill past capacity with fresh keys
        repeat (70)
        begin
            op = random_op(POOL_SIZE, 100);
            op.key = $urandom;
            op.may_insert = 1'b1;
            send_op(op, 1'b0, '0);
        end

        // near-full traffic with no idling on either side
        no_stall = 1'b1;
        repeat (150)
            send_op(random_op(POOL_SIZE, 50), 1'b0, '0);
        no_stall = 1'b0;

        // empty the table by erasing stored keys at random slots
        while (shadow_count > 0)
        begin
            op = random_op(POOL_SIZE, 0);
            op.opcode = ($urandom_range(4) == 0) ? okvt_pkg::OP_LOOKUP : okvt_pkg::OP_ERASE;
            op.key = shadow_keys[$urandom_range(shadow_count - 1)];
            send_op(op, 1'b0, '0);
        end

        repeat (200)
            send_op(random_op(16, 40), 1'b0, '0);

        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
